[design/rdx_pkg.sv]
// rdx_pkg: shared constants, types and helpers for the radix digit converter
// used by rdx_base, rdx_div and signed_integer_to_radix_digits; no dependencies

package rdx_pkg;

  localparam int MAX_SYMBOLS = 16;
  localparam int SYM_W       = 8;
  localparam int TAB_W       = MAX_SYMBOLS * SYM_W;
  localparam int IDX_W       = $clog2(MAX_SYMBOLS);
  localparam int LEN_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int NUM_BITS    = 32;
  localparam int CNT_W       = $clog2(NUM_BITS);
  localparam int ND_W        = $clog2(NUM_BITS + 1);
  localparam int STACK_W     = NUM_BITS * IDX_W;
  localparam int CFG_W       = 64;

  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'd43;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'd45;
  localparam logic [LEN_W-1:0] MIN_BASE  = LEN_W'(2);

  // register indexes on the configuration port
  localparam logic CFG_SYMBOLS_LOW  = 1'b0;
  localparam logic CFG_SYMBOLS_HIGH = 1'b1;

  localparam logic [CFG_W-1:0] SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_W-1:0] SYMBOLS_HIGH_RST = 64'h0000_0000_0000_3938;

  typedef struct packed {
    logic             done;
    logic             ok;
    logic [LEN_W-1:0] len;
  } base_status_t;

  typedef struct packed {
    logic                done;
    logic [NUM_BITS-1:0] quo;
    logic [IDX_W-1:0]    rem;
  } div_result_t;

  function automatic logic [SYM_W-1:0] sym_at(input logic [TAB_W-1:0] sym_tab,
                                              input logic [IDX_W-1:0] idx);
    return sym_tab[idx*SYM_W +: SYM_W];
  endfunction

endpackage

[design/signed_integer_to_radix_digits.sv]
// signed_integer_to_radix_digits: signed 32-bit number to text in a configured radix
// depends on rdx_pkg, rdx_base, rdx_div
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+-------------------------------------------
//  s_axis   | in  | s_tvalid/s_tready | s_tdata[31:0] number (signed)
//  m_axis   | out | m_tvalid/m_tready | m_tdata[7:0] out_char, m_tlast last
//  cfg      | in  | cfg_we            | cfg_index (0 symbols_low, 1 symbols_high),
//           |     |                   | cfg_data[63:0]
//
// one request at a time: a scan of the symbol table, then one bit-serial division
// per digit, then one byte per cycle while the output side is ready, a minus sign
// first for a negative number; a symbol table that fails the scan gives no output
// reset (rst, synchronous) restores the decimal symbol table and empties the output
// a stalled output holds its byte; the next request is taken as soon as the
// last byte of the current one is in the output register

module signed_integer_to_radix_digits (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,   // [31:0] number
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // [7:0] out_char
  output logic                      m_tlast,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [rdx_pkg::CFG_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    DIVIDE,
    SIGN,
    EMIT
  } state_t;

  state_t                        state;
  logic [rdx_pkg::CFG_W-1:0]     symbols_low;
  logic [rdx_pkg::CFG_W-1:0]     symbols_high;
  logic [rdx_pkg::TAB_W-1:0]     syms;
  logic                          neg;
  logic [rdx_pkg::NUM_BITS-1:0]  mag;
  logic [rdx_pkg::STACK_W-1:0]   stack;   // digit stack, newest in the low nibble
  logic [rdx_pkg::ND_W-1:0]      nd;
  logic [rdx_pkg::ND_W-1:0]      nd_next;
  logic                          base_start;
  logic                          div_start;
  rdx_pkg::base_status_t         base_st;
  rdx_pkg::div_result_t          div_res;
  logic                          out_free;
  logic                          emit_now;

  assign syms     = {symbols_high, symbols_low};
  assign s_tready = (state == IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign nd_next  = nd + 1'b1;
  // a byte is loaded whenever the output register is free and text is due
  assign emit_now = out_free && (state == SIGN || state == EMIT);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_low  <= rdx_pkg::SYMBOLS_LOW_RST;
      symbols_high <= rdx_pkg::SYMBOLS_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rdx_pkg::CFG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        rdx_pkg::CFG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  rdx_base u_base (
    .clk    (clk),
    .rst    (rst),
    .start  (base_start),
    .syms   (syms),
    .status (base_st)
  );

  rdx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (base_st.len),
    .result   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      m_tvalid   <= 1'b0;
      base_start <= 1'b0;
      div_start  <= 1'b0;
      nd         <= '0;
    end else begin
      base_start <= 1'b0;
      div_start  <= 1'b0;
      if (emit_now) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            neg        <= s_tdata[31];
            // two's complement magnitude; the most negative value maps to 2^31
            mag        <= s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;
            base_start <= 1'b1;
            state      <= CHECK;
          end
        end
        CHECK: begin
          if (base_st.done) begin
            if (base_st.ok) begin
              nd        <= '0;
              div_start <= 1'b1;
              state     <= DIVIDE;
            end else begin
              state <= IDLE;
            end
          end
        end
        DIVIDE: begin
          if (div_res.done) begin
            stack <= {stack[rdx_pkg::STACK_W-rdx_pkg::IDX_W-1:0], div_res.rem};
            nd    <= nd_next;
            mag   <= div_res.quo;
            if (div_res.quo != '0 && nd_next < rdx_pkg::ND_W'(rdx_pkg::NUM_BITS)) begin
              div_start <= 1'b1;
            end else begin
              state <= neg ? SIGN : EMIT;
            end
          end
        end
        SIGN: begin
          if (out_free) begin
            m_tdata  <= rdx_pkg::SYM_MINUS;
            m_tlast  <= 1'b0;
            state    <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            m_tdata  <= rdx_pkg::sym_at(syms, stack[rdx_pkg::IDX_W-1:0]);
            m_tlast  <= (nd == rdx_pkg::ND_W'(1));
            stack    <= {{rdx_pkg::IDX_W{1'b0}}, stack[rdx_pkg::STACK_W-1:rdx_pkg::IDX_W]};
            nd       <= nd - 1'b1;
            if (nd == rdx_pkg::ND_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[design/rdx_base.sv]
// rdx_base: base length and serial validity scan of the symbol table
// depends on rdx_pkg

module rdx_base (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rdx_pkg::TAB_W-1:0] syms,
  output rdx_pkg::base_status_t     status
);

  logic [rdx_pkg::LEN_W-1:0] len;
  logic [rdx_pkg::IDX_W-1:0] a;
  logic                      busy;
  logic                      bad;
  logic                      done;
  logic                      ok;
  logic [rdx_pkg::SYM_W-1:0] ca;
  logic                      hit;

  // first zero byte ends the base
  always_comb begin
    len = rdx_pkg::LEN_W'(rdx_pkg::MAX_SYMBOLS);
    for (int i = rdx_pkg::MAX_SYMBOLS - 1; i >= 0; i--) begin
      if (rdx_pkg::sym_at(syms, rdx_pkg::IDX_W'(i)) == '0) begin
        len = rdx_pkg::LEN_W'(i);
      end
    end
  end

  // one symbol a cycle against all later ones and against the plus and minus signs
  always_comb begin
    ca  = rdx_pkg::sym_at(syms, a);
    hit = 1'b0;
    if ({1'b0, a} < len) begin
      if (ca == rdx_pkg::SYM_PLUS || ca == rdx_pkg::SYM_MINUS) begin
        hit = 1'b1;
      end
      for (int b = 0; b < rdx_pkg::MAX_SYMBOLS; b++) begin
        if (rdx_pkg::LEN_W'(b) > {1'b0, a} && rdx_pkg::LEN_W'(b) < len &&
            rdx_pkg::sym_at(syms, rdx_pkg::IDX_W'(b)) == ca) begin
          hit = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bad  <= 1'b0;
      ok   <= 1'b0;
      a    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bad  <= 1'b0;
        a    <= '0;
      end else if (busy) begin
        bad <= bad | hit;
        a   <= a + 1'b1;
        if (a == rdx_pkg::IDX_W'(rdx_pkg::MAX_SYMBOLS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          ok   <= !(bad | hit) && (len >= rdx_pkg::MIN_BASE);
        end
      end
    end
  end

  assign status.done = done;
  assign status.ok   = ok;
  assign status.len  = len;

endmodule

[design/rdx_div.sv]
// rdx_div: bit-serial restoring divider, one quotient bit a cycle
// depends on rdx_pkg

module rdx_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rdx_pkg::NUM_BITS-1:0] dividend,
  input  logic [rdx_pkg::LEN_W-1:0]    divisor,
  output rdx_pkg::div_result_t         result
);

  logic [rdx_pkg::NUM_BITS-1:0] q;
  logic [rdx_pkg::IDX_W-1:0]    rem;
  logic [rdx_pkg::CNT_W-1:0]    cnt;
  logic                         busy;
  logic                         done;
  logic [rdx_pkg::LEN_W-1:0]    trial;
  logic                         fits;
  logic [rdx_pkg::LEN_W-1:0]    diff;

  assign trial = {rem, q[rdx_pkg::NUM_BITS-1]};
  assign fits  = trial >= divisor;
  assign diff  = trial - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == rdx_pkg::CNT_W'(rdx_pkg::NUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
    end else if (busy) begin
      q   <= {q[rdx_pkg::NUM_BITS-2:0], fits};
      rem <= fits ? diff[rdx_pkg::IDX_W-1:0] : trial[rdx_pkg::IDX_W-1:0];
    end
  end

  assign result.done = done;
  assign result.quo  = q;
  assign result.rem  = rem;

endmodule

[design/rdx_check.sv]
// rdx_check: port-level assertions for signed_integer_to_radix_digits
// depends on rdx_pkg; bound to the top level below

module rdx_check (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // a stalled output byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output byte changed while stalled");

  // while waiting for a request only the final byte may still be pending
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tlast)
    else $error("idle with a non-final byte pending");

  // a taken request blocks the input side next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a request");

  // no byte appears straight out of idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready && !m_tvalid |=> !m_tvalid)
    else $error("byte emitted without a request in progress");

  // a minus sign is never the final byte
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata == rdx_pkg::SYM_MINUS |-> !m_tlast)
    else $error("minus sign flagged as last");

endmodule

bind signed_integer_to_radix_digits rdx_check u_rdx_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
